// ----- rtl/lobl_pkg.sv -----
package lobl_pkg;

    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int ID_W    = 32;
    localparam int TOT_W   = 48;
    // order count of one level, wide enough for the largest order store
    localparam int ORD_W   = 17;

    // command codes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_MODIFY = 3'd2;
    localparam logic [2:0] OP_BEST   = 3'd3;
    localparam logic [2:0] OP_SNAP   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_ORD_FULL  = 3'd3;
    localparam logic [2:0] ST_LVL_FULL  = 3'd4;

    typedef enum logic [2:0] {
        LV_NOP,
        LV_ADD,
        LV_INS,
        LV_SUB,
        LV_DEL
    } t_lvl_op;

    typedef struct packed {
        t_lvl_op              op;
        logic [PRICE_W-1:0]   price;
        logic [QTY_W-1:0]     qty;
    } t_lvl_cmd;

    typedef struct packed {
        logic                 valid;
        logic [PRICE_W-1:0]   price;
        logic [TOT_W-1:0]     total;
        logic [ORD_W-1:0]     orders;
    } t_lvl_cell;

    typedef struct packed {
        logic hit;
        logic hit_one;
        logic full;
    } t_chain_stat;

    typedef struct packed {
        logic                 valid;
        logic [ID_W-1:0]      id;
        logic [PRICE_W-1:0]   price;
        logic                 side;
        logic [QTY_W-1:0]     qty;
    } t_slot;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LVCHK,
        S_SCAN,
        S_FOUND,
        S_ADD_DO,
        S_CAN_DO,
        S_MCHK1,
        S_MCHK2,
        S_MINS,
        S_SNAP,
        S_EMIT,
        S_OUT
    } t_state;

endpackage

// ----- rtl/lobl_cell.sv -----
module lobl_cell
    import lobl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_is_ask,
    input  t_lvl_cmd   i_cmd,
    input  t_lvl_cell  i_left,
    input  logic       i_left_cond,
    input  t_lvl_cell  i_right,
    output t_lvl_cell  o_cell,
    output logic       o_cond,
    output logic       o_match,
    output logic       o_match_one
);

    logic                 r_valid;
    logic [PRICE_W-1:0]   r_price;
    logic [TOT_W-1:0]     r_total;
    logic [ORD_W-1:0]     r_orders;
    logic                 n_valid;
    logic [PRICE_W-1:0]   n_price;
    logic [TOT_W-1:0]     n_total;
    logic [ORD_W-1:0]     n_orders;
    logic                 beats;
    logic                 after;

    // compare own level against the broadcast price
    always_comb begin
        beats       = i_is_ask ? (r_price > i_cmd.price) : (r_price < i_cmd.price);
        o_match     = r_valid && (r_price == i_cmd.price);
        o_match_one = o_match && (r_orders == ORD_W'(1));
        o_cond      = !r_valid || beats;
        after       = r_valid && (beats || (r_price == i_cmd.price));
    end

    assign o_cell = '{valid: r_valid, price: r_price, total: r_total, orders: r_orders};

    // update, insert with shift from the left, or delete with shift from the right
    always_comb begin
        n_valid  = r_valid;
        n_price  = r_price;
        n_total  = r_total;
        n_orders = r_orders;
        case (i_cmd.op)
            LV_ADD: begin
                if (o_match) begin
                    n_total  = r_total + TOT_W'(i_cmd.qty);
                    n_orders = r_orders + ORD_W'(1);
                end
            end
            LV_SUB: begin
                if (o_match) begin
                    n_total  = r_total - TOT_W'(i_cmd.qty);
                    n_orders = r_orders - ORD_W'(1);
                end
            end
            LV_INS: begin
                if (o_cond) begin
                    if (i_left_cond) begin
                        n_valid  = i_left.valid;
                        n_price  = i_left.price;
                        n_total  = i_left.total;
                        n_orders = i_left.orders;
                    end else begin
                        n_valid  = 1'b1;
                        n_price  = i_cmd.price;
                        n_total  = TOT_W'(i_cmd.qty);
                        n_orders = ORD_W'(1);
                    end
                end
            end
            LV_DEL: begin
                if (after) begin
                    n_valid  = i_right.valid;
                    n_price  = i_right.price;
                    n_total  = i_right.total;
                    n_orders = i_right.orders;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_price  <= n_price;
        r_total  <= n_total;
        r_orders <= n_orders;
    end

endmodule

// ----- rtl/lobl_chain.sv -----
module lobl_chain
    import lobl_pkg::*;
#(
    parameter int N         = 64,
    parameter int MAX_DEPTH = 16,
    parameter int USED_W    = $clog2(N + 1),
    parameter int RD_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_is_ask,
    input  t_lvl_cmd          i_cmd,
    input  logic [RD_W-1:0]   i_rd_idx,
    output t_chain_stat       o_stat,
    output t_lvl_cell         o_best,
    output t_lvl_cell         o_rd,
    output logic [USED_W-1:0] o_used
);

    localparam int RD_N = (MAX_DEPTH < N) ? MAX_DEPTH : N;

    t_lvl_cell          cells [N];
    logic [N-1:0]       cond;
    logic [N-1:0]       match;
    logic [N-1:0]       match_one;
    logic [USED_W-1:0]  r_used;

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < N; g++) begin : g_cell
        t_lvl_cell left;
        t_lvl_cell right;
        logic      left_cond;
        if (g == 0) begin : g_head
            assign left      = '0;
            assign left_cond = 1'b0;
        end else begin : g_body
            assign left      = cells[g-1];
            assign left_cond = cond[g-1];
        end
        if (g == N - 1) begin : g_tail
            assign right = '0;
        end else begin : g_mid
            assign right = cells[g+1];
        end
        lobl_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_is_ask    (i_is_ask),
            .i_cmd       (i_cmd),
            .i_left      (left),
            .i_left_cond (left_cond),
            .i_right     (right),
            .o_cell      (cells[g]),
            .o_cond      (cond[g]),
            .o_match     (match[g]),
            .o_match_one (match_one[g])
        );
    end

    assign o_stat.hit     = |match;
    assign o_stat.hit_one = |match_one;
    assign o_stat.full    = (r_used == USED_W'(N));
    assign o_best         = cells[0];
    assign o_used         = r_used;

    // select one of the leading levels for snapshot readout
    always_comb begin
        o_rd = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (i_rd_idx == RD_W'(i)) begin
                o_rd = cells[i];
            end
        end
    end

    // track the number of levels in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.op == LV_INS && !o_stat.full) begin
            r_used <= r_used + USED_W'(1);
        end else if (i_cmd.op == LV_DEL && r_used != '0) begin
            r_used <= r_used - USED_W'(1);
        end
    end

endmodule

// ----- rtl/limit_order_book_levels_unit.sv -----
// Limit order book with price levels, no matching.
// Commands arrive on the s_axis channel, one item per command; results leave on
// m_axis. Each command gives one result item with tlast set; a depth snapshot
// gives one item per returned level (bids best first, then asks), tlast on the
// final one, or a single empty item when no level is returned.
// A best query or a command rejected on its fields goes from acceptance
// straight to the result; an add refused by a full level store passes a level
// check first. Commands that need the order store scan it one slot a cycle
// through its read port; an identifier that is not resting is reported after
// the whole store is scanned. Level updates act on a row of cells per side
// that shift neighbor to neighbor. A snapshot reads one level per item and
// waits for each item to be taken before it reads the next.
// One command is in work at a time; s_axis_tready is high only while the block
// is idle, from the cycle after the last result item leaves.
// After reset the block clears the order store, one slot a cycle, before it
// accepts the first command.
// A result waits in the output register while m_axis_tready is low; no command
// is taken until it and any further snapshot items are delivered.
module limit_order_book_levels_unit
    import lobl_pkg::*;
#(
    parameter int ORDER_SLOTS     = 1024,
    parameter int LEVELS_PER_SIDE = 64,
    parameter int MAX_DEPTH       = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // side, price, quantity, order identifier, depth
    input  logic [103:0] s_axis_tdata,
    // opcode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, new_id, top bid price, top ask price, top bid quantity,
    // top ask quantity, level_side, level_price, level_qty, open_orders
    output logic [287:0] m_axis_tdata,
    // level_valid
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int ADDR_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
    localparam int USED_W = $clog2(LEVELS_PER_SIDE + 1);
    localparam int RD_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DS_W   = $clog2(MAX_DEPTH + 1);
    localparam int K_W    = $clog2(2 * MAX_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ORDER_SLOTS - 1);

    t_state r_state, n_state;

    // unpacked input fields
    logic               in_side;
    logic [PRICE_W-1:0] in_price;
    logic [QTY_W-1:0]   in_qty;
    logic [ID_W-1:0]    in_oid;
    logic [4:0]         in_depth;
    logic               accept;

    assign in_side  = s_axis_tdata[0];
    assign in_price = s_axis_tdata[32:1];
    assign in_qty   = s_axis_tdata[64:33];
    assign in_oid   = s_axis_tdata[96:65];
    assign in_depth = s_axis_tdata[101:97];
    assign accept   = s_axis_tvalid && s_axis_tready;

    // command registers
    logic [2:0]          r_op;
    logic [PRICE_W-1:0]  r_price;
    logic [QTY_W-1:0]    r_qty;
    logic [ID_W-1:0]     r_oid;
    logic                r_side;

    // level command registers
    logic [PRICE_W-1:0]  r_cp;
    logic [QTY_W-1:0]    r_cq;
    logic                r_cs;
    logic                r_hit;
    logic                r_full;

    // order store and scan
    t_slot               mem [ORDER_SLOTS];
    t_slot               r_rd;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic                r_rd_ok;
    logic [ADDR_W-1:0]   r_slot;
    logic [PRICE_W-1:0]  r_sp;
    logic [QTY_W-1:0]    r_sq;
    logic                r_ss;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    t_slot               mem_wd;
    logic                slot_hit;

    // book counters
    logic [ID_W-1:0]     r_next_id;
    logic [CNT_W-1:0]    r_count;

    // snapshot control
    logic [K_W-1:0]      r_k;
    logic [DS_W-1:0]     r_nb;
    logic [DS_W-1:0]     r_na;
    logic [DS_W-1:0]     ds;
    logic [K_W-1:0]      snap_n;

    // pending result
    logic [2:0]          r_st;
    logic [ID_W-1:0]     r_id;
    logic                r_lvv;
    logic                r_lvs;
    logic [PRICE_W-1:0]  r_lvp;
    logic [TOT_W-1:0]    r_lvq;
    logic                r_last;

    // output register
    logic [2:0]          r_o_st;
    logic [ID_W-1:0]     r_o_id;
    logic [PRICE_W-1:0]  r_o_bbp;
    logic [PRICE_W-1:0]  r_o_bap;
    logic [TOT_W-1:0]    r_o_bbq;
    logic [TOT_W-1:0]    r_o_baq;
    logic                r_o_lvv;
    logic                r_o_lvs;
    logic [PRICE_W-1:0]  r_o_lvp;
    logic [TOT_W-1:0]    r_o_lvq;
    logic                r_o_last;
    logic [10:0]         r_o_open;

    // level chains
    t_lvl_op             lv_op;
    t_lvl_cmd            cmd_bid, cmd_ask;
    t_chain_stat         st_bid, st_ask, st_sel;
    t_lvl_cell           top_bid, top_ask, rd_bid, rd_ask;
    logic [USED_W-1:0]   used_bid, used_ask;
    logic [K_W-1:0]      ask_k;

    assign cmd_bid = '{op: (r_cs ? LV_NOP : lv_op), price: r_cp, qty: r_cq};
    assign cmd_ask = '{op: (r_cs ? lv_op : LV_NOP), price: r_cp, qty: r_cq};
    assign st_sel  = r_cs ? st_ask : st_bid;
    assign ask_k   = r_k - K_W'(r_nb);

    lobl_chain #(
        .N         (LEVELS_PER_SIDE),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_bid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_is_ask (1'b0),
        .i_cmd    (cmd_bid),
        .i_rd_idx (r_k[RD_W-1:0]),
        .o_stat   (st_bid),
        .o_best   (top_bid),
        .o_rd     (rd_bid),
        .o_used   (used_bid)
    );

    lobl_chain #(
        .N         (LEVELS_PER_SIDE),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ask (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_is_ask (1'b1),
        .i_cmd    (cmd_ask),
        .i_rd_idx (ask_k[RD_W-1:0]),
        .o_stat   (st_ask),
        .o_best   (top_ask),
        .o_rd     (rd_ask),
        .o_used   (used_ask)
    );

    // snapshot depth saturation and total count
    always_comb begin
        ds     = (32'(in_depth) > MAX_DEPTH) ? DS_W'(MAX_DEPTH) : DS_W'(in_depth);
        snap_n = K_W'(r_nb) + K_W'(r_na);
    end

    // scan match: free slot for add, identifier otherwise
    assign slot_hit = (r_op == OP_ADD) ? !r_rd.valid
                                       : (r_rd.valid && (r_rd.id == r_oid));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        OP_ADD: begin
                            if (in_price == '0 || in_qty == '0) begin
                                n_state = S_EMIT;
                            end else if (32'(r_count) >= ORDER_SLOTS) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_LVCHK;
                            end
                        end
                        OP_CANCEL: n_state = S_SCAN;
                        OP_MODIFY: n_state = (in_price == '0) ? S_EMIT : S_SCAN;
                        OP_SNAP:   n_state = S_SNAP;
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_LVCHK: n_state = (!st_sel.hit && st_sel.full) ? S_EMIT : S_SCAN;
            S_SCAN: begin
                if (r_rd_ok) begin
                    if (slot_hit) begin
                        n_state = S_FOUND;
                    end else if (r_rd_addr == LAST_ADDR) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_FOUND: begin
                case (r_op)
                    OP_ADD:    n_state = S_ADD_DO;
                    OP_CANCEL: n_state = S_CAN_DO;
                    default:   n_state = (r_sp == r_price) ? S_EMIT : S_MCHK1;
                endcase
            end
            S_ADD_DO: n_state = S_EMIT;
            S_CAN_DO: n_state = S_EMIT;
            S_MCHK1:  n_state = S_MCHK2;
            S_MCHK2:  n_state = (!r_hit && r_full && !st_sel.hit_one) ? S_EMIT : S_MINS;
            S_MINS:   n_state = S_EMIT;
            S_SNAP:   n_state = S_EMIT;
            S_EMIT:   n_state = S_OUT;
            S_OUT: begin
                if (m_axis_tready) n_state = r_o_last ? S_IDLE : S_SNAP;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // level commands and store writes
    always_comb begin
        lv_op  = LV_NOP;
        mem_we = 1'b0;
        mem_wa = r_slot;
        mem_wd = '{valid: 1'b1, id: r_oid, price: r_price, side: r_ss, qty: r_sq};
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_addr;
                mem_wd = '0;
            end
            S_ADD_DO: begin
                lv_op  = r_hit ? LV_ADD : LV_INS;
                mem_we = 1'b1;
                mem_wd = '{valid: 1'b1, id: r_next_id, price: r_price,
                           side: r_side, qty: r_qty};
            end
            S_CAN_DO: begin
                lv_op  = st_sel.hit_one ? LV_DEL : (st_sel.hit ? LV_SUB : LV_NOP);
                mem_we = 1'b1;
                mem_wd = '0;
            end
            S_MCHK2: begin
                if (r_hit || !r_full || st_sel.hit_one) begin
                    lv_op  = st_sel.hit_one ? LV_DEL : (st_sel.hit ? LV_SUB : LV_NOP);
                    mem_we = 1'b1;
                end
            end
            S_MINS: lv_op = r_hit ? LV_ADD : LV_INS;
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);

    // order store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[r_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_rd_ok   <= 1'b0;
            r_next_id <= ID_W'(1);
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            r_rd_ok <= (r_state == S_SCAN);
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                if (r_addr != LAST_ADDR) r_addr <= r_addr + ADDR_W'(1);
            end else begin
                r_addr <= '0;
            end
            if (r_state == S_ADD_DO) begin
                r_next_id <= (r_next_id == '1) ? ID_W'(1) : r_next_id + ID_W'(1);
                r_count   <= r_count + CNT_W'(1);
            end
            if (r_state == S_CAN_DO && r_count != '0) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_addr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op    <= s_axis_tuser;
                    r_side  <= in_side;
                    r_price <= in_price;
                    r_qty   <= in_qty;
                    r_oid   <= in_oid;
                    r_cp    <= in_price;
                    r_cq    <= in_qty;
                    r_cs    <= in_side;
                    r_k     <= '0;
                    r_nb    <= (32'(used_bid) < 32'(ds)) ? DS_W'(used_bid) : ds;
                    r_na    <= (32'(used_ask) < 32'(ds)) ? DS_W'(used_ask) : ds;
                    r_id    <= '0;
                    r_lvv   <= 1'b0;
                    r_lvs   <= 1'b0;
                    r_lvp   <= '0;
                    r_lvq   <= '0;
                    r_last  <= 1'b1;
                    case (s_axis_tuser)
                        OP_ADD: begin
                            if (in_price == '0 || in_qty == '0) begin
                                r_st <= ST_INVALID;
                            end else if (32'(r_count) >= ORDER_SLOTS) begin
                                r_st <= ST_ORD_FULL;
                            end else begin
                                r_st <= ST_OK;
                            end
                        end
                        OP_CANCEL: r_st <= ST_OK;
                        OP_MODIFY: r_st <= (in_price == '0) ? ST_INVALID : ST_OK;
                        OP_BEST:   r_st <= ST_OK;
                        OP_SNAP:   r_st <= ST_OK;
                        default:   r_st <= ST_INVALID;
                    endcase
                end
            end
            S_LVCHK: begin
                r_hit <= st_sel.hit;
                if (!st_sel.hit && st_sel.full) r_st <= ST_LVL_FULL;
            end
            S_SCAN: begin
                if (r_rd_ok) begin
                    if (slot_hit) begin
                        r_slot <= r_rd_addr;
                        r_sp   <= r_rd.price;
                        r_sq   <= r_rd.qty;
                        r_ss   <= r_rd.side;
                    end else if (r_rd_addr == LAST_ADDR) begin
                        r_st <= (r_op == OP_ADD) ? ST_ORD_FULL : ST_NOT_FOUND;
                    end
                end
            end
            S_FOUND: begin
                if (r_op == OP_CANCEL) begin
                    r_cp <= r_sp;
                    r_cq <= r_sq;
                    r_cs <= r_ss;
                end else if (r_op == OP_MODIFY) begin
                    r_cp <= r_price;
                    r_cq <= r_sq;
                    r_cs <= r_ss;
                end
            end
            S_ADD_DO: r_id <= r_next_id;
            S_MCHK1: begin
                r_hit  <= st_sel.hit;
                r_full <= st_sel.full;
                r_cp   <= r_sp;
            end
            S_MCHK2: begin
                if (!r_hit && r_full && !st_sel.hit_one) begin
                    r_st <= ST_LVL_FULL;
                end
                r_cp <= r_price;
            end
            S_SNAP: begin
                if (snap_n == '0) begin
                    r_lvv  <= 1'b0;
                    r_last <= 1'b1;
                end else begin
                    r_lvv <= 1'b1;
                    if (r_k < K_W'(r_nb)) begin
                        r_lvs <= 1'b0;
                        r_lvp <= rd_bid.price;
                        r_lvq <= rd_bid.total;
                    end else begin
                        r_lvs <= 1'b1;
                        r_lvp <= rd_ask.price;
                        r_lvq <= rd_ask.total;
                    end
                    r_last <= (r_k + K_W'(1) == snap_n);
                    r_k    <= r_k + K_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // load the output register with the top of book after the update
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_o_st   <= r_st;
            r_o_id   <= r_id;
            r_o_bbp  <= top_bid.valid ? top_bid.price : '0;
            r_o_bap  <= top_ask.valid ? top_ask.price : '0;
            r_o_bbq  <= top_bid.valid ? top_bid.total : '0;
            r_o_baq  <= top_ask.valid ? top_ask.total : '0;
            r_o_lvv  <= r_lvv;
            r_o_lvs  <= r_lvv & r_lvs;
            r_o_lvp  <= r_lvv ? r_lvp : '0;
            r_o_lvq  <= r_lvv ? r_lvq : '0;
            r_o_last <= r_last;
            r_o_open <= 11'(r_count);
        end
    end

    assign m_axis_tdata = {1'b0, r_o_open, r_o_lvq, r_o_lvp, r_o_lvs, r_o_baq, r_o_bbq,
                           r_o_bap, r_o_bbp, r_o_id, r_o_st};
    assign m_axis_tuser = r_o_lvv;
    assign m_axis_tlast = r_o_last;

endmodule
